### hdl/ftrd_pkg.sv
// ftrd_pkg: shared constants, command/status structs and the digit-to-ASCII
// function for the fixed-point to radix-digit converter.
// No dependencies.
`timescale 1ns / 1ps

package ftrd_pkg;

   localparam int DEF_INT_BITS        = 24;
   localparam int DEF_FRAC_BITS       = 24;
   localparam int DEF_MAX_FRAC_DIGITS = 24;

   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 7;
   localparam int DIV_BITS = 4;   // quotient bits resolved per divider cycle

   localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
   localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;  // '0'
   localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;  // 'A'
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 7'h2E;  // '.'

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic div_push;
      logic emit_int;
      logic emit_dot;
      logic emit_frac;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic in_int_zero;
      logic quot_zero_next;
      logic int_cnt_one;
      logic frac_zero;
      logic frac_last;
      logic out_free;
   } sts_type;

   // number of DIV_BITS-bit divider steps that cover an int_bits-wide quotient
   function automatic int div_steps(input int int_bits);
      return (int_bits + DIV_BITS - 1) / DIV_BITS;
   endfunction

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] ch;
      if (d < DEC_DIGITS) begin
         ch = CHAR_ZERO + CHAR_W'(d);
      end else begin
         ch = CHAR_A + CHAR_W'(d - DEC_DIGITS);
      end
      return ch;
   endfunction

endpackage

### hdl/ftrd_ctrl.sv
// ftrd_ctrl: sequencing state machine for the radix converter.
// Depends on ftrd_pkg; drives ftrd_dpath through cmd_type/sts_type.
`timescale 1ns / 1ps

module ftrd_ctrl
   import ftrd_pkg::*;
#(
   parameter int INT_BITS = DEF_INT_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam int NSTEP  = div_steps(INT_BITS);
   localparam int STEP_W = (NSTEP > 1) ? $clog2(NSTEP) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_INT  = 3'd2;
   localparam logic [2:0] S_DOT  = 3'd3;
   localparam logic [2:0] S_FRAC = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = sts.in_int_zero ? S_DOT : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(NSTEP - 1)) begin
               cmd.div_push = 1'b1;
               step_in      = '0;
               if (sts.quot_zero_next) begin
                  state_in = S_INT;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_INT: begin
            if (sts.out_free) begin
               cmd.emit_int = 1'b1;
               if (sts.int_cnt_one) begin
                  state_in = S_DOT;
               end
            end
         end
         S_DOT: begin
            if (sts.out_free) begin
               cmd.emit_dot = 1'b1;
               state_in     = sts.frac_zero ? S_IDLE : S_FRAC;
            end
         end
         S_FRAC: begin
            if (sts.out_free) begin
               cmd.emit_frac = 1'b1;
               if (sts.frac_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

### hdl/ftrd_dpath.sv
// ftrd_dpath: divider, fraction multiplier, integer digit stack and the
// result register of the radix converter. Depends on ftrd_pkg.
`timescale 1ns / 1ps

module ftrd_dpath
   import ftrd_pkg::*;
#(
   parameter int INT_BITS        = DEF_INT_BITS,
   parameter int FRAC_BITS       = DEF_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [INT_BITS-1:0]  in_int,
   input  logic [FRAC_BITS-1:0] in_frac,
   input  logic [RADIX_W-1:0]   in_radix,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHAR_W-1:0]    rsp_char,
   output logic                 rsp_last,
   output logic                 rsp_trunc
);

   localparam int DW     = div_steps(INT_BITS) * DIV_BITS;
   localparam int CNT_W  = $clog2(INT_BITS + 1);
   localparam int IDX_W  = $clog2(INT_BITS);
   localparam int FCNT_W = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int PW     = FRAC_BITS + RADIX_W;

   logic [DW-1:0]        quot_ff, quot_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [RADIX_W-1:0]   radix_ff, radix_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [CNT_W-1:0]     int_cnt_ff, int_cnt_in;
   logic [FCNT_W-1:0]    frac_cnt_ff, frac_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_trunc_ff, rsp_trunc_in;

   logic [RADIX_W-1:0]   digit_store [INT_BITS];

   logic [DW-1:0]        div_q;
   logic [RADIX_W-1:0]   div_r;
   logic [RADIX_W:0]     trial;
   logic [RADIX_W-1:0]   radix_sat;
   logic [PW-1:0]        prod;
   logic [RADIX_W-1:0]   frac_digit;
   logic [FRAC_BITS-1:0] frac_next;
   logic                 frac_cap;
   logic [IDX_W-1:0]     rd_idx;
   logic                 out_free;

   assign radix_sat = (in_radix < RADIX_MIN) ? RADIX_MIN :
                      (in_radix > RADIX_MAX) ? RADIX_MAX : in_radix;

   // restoring division, DIV_BITS quotient bits per cycle
   always_comb begin
      div_q = quot_ff;
      div_r = rem_ff;
      trial = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {div_r, div_q[DW-1]};
         div_q = {div_q[DW-2:0], 1'b0};
         if (trial >= {1'b0, radix_ff}) begin
            div_r    = RADIX_W'(trial - {1'b0, radix_ff});
            div_q[0] = 1'b1;
         end else begin
            div_r = trial[RADIX_W-1:0];
         end
      end
   end

   // fraction digit: integer bits of frac * radix
   assign prod       = PW'(frac_ff) * PW'(radix_ff);
   assign frac_digit = prod[FRAC_BITS +: RADIX_W];
   assign frac_next  = prod[FRAC_BITS-1:0];
   assign frac_cap   = (frac_cnt_ff == FCNT_W'(MAX_FRAC_DIGITS - 1));

   assign rd_idx   = IDX_W'(int_cnt_ff - 1'b1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign sts.in_int_zero    = (in_int == '0);
   assign sts.quot_zero_next = (div_q == '0);
   assign sts.int_cnt_one    = (int_cnt_ff == CNT_W'(1));
   assign sts.frac_zero      = (frac_ff == '0);
   assign sts.frac_last      = (frac_next == '0) || frac_cap;
   assign sts.out_free       = out_free;

   always_comb begin
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      frac_in      = frac_ff;
      int_cnt_in   = int_cnt_ff;
      frac_cnt_in  = frac_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;
      if (cmd.load) begin
         quot_in     = DW'(in_int);
         rem_in      = '0;
         radix_in    = radix_sat;
         frac_in     = in_frac;
         int_cnt_in  = '0;
         frac_cnt_in = '0;
      end
      if (cmd.div_step) begin
         quot_in = div_q;
         rem_in  = div_r;
         if (cmd.div_push) begin
            rem_in     = '0;
            int_cnt_in = int_cnt_ff + 1'b1;
         end
      end
      if (cmd.emit_int) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = digit_to_char(digit_store[rd_idx]);
         rsp_last_in  = 1'b0;
         rsp_trunc_in = 1'b0;
         int_cnt_in   = int_cnt_ff - 1'b1;
      end
      if (cmd.emit_dot) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = CHAR_DOT;
         rsp_last_in  = (frac_ff == '0);
         rsp_trunc_in = 1'b0;
      end
      if (cmd.emit_frac) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = digit_to_char(frac_digit);
         rsp_last_in  = (frac_next == '0) || frac_cap;
         rsp_trunc_in = frac_cap && (frac_next != '0);
         frac_in      = frac_next;
         frac_cnt_in  = frac_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_cnt_ff   <= '0;
         frac_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         int_cnt_ff   <= int_cnt_in;
         frac_cnt_ff  <= frac_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      radix_ff     <= radix_in;
      frac_ff      <= frac_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   // digit stack, pushed low digit first
   always_ff @(posedge clock) begin
      if (cmd.div_push) begin
         digit_store[int_cnt_ff[IDX_W-1:0]] <= div_r;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_trunc = rsp_trunc_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_int || cmd.emit_dot || cmd.emit_frac) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_int |-> (int_cnt_ff != '0))
      else $error("digit stack popped while empty");

   a_frac_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_frac |-> (frac_ff != '0))
      else $error("fraction digit emitted from zero remainder");

   a_trunc_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_trunc_ff) |-> rsp_last_ff)
      else $error("truncated flag without last");

endmodule

### hdl/fixed_to_radix_digits.sv
// fixed_to_radix_digits: top level of the fixed-point to radix-digit converter.
// Depends on ftrd_pkg, ftrd_ctrl and ftrd_dpath.
`timescale 1ns / 1ps
//
// Usage:
//  - req channel: one transaction carries an unsigned fixed-point value
//    (int_part, frac_part) and a radix; radix values below 2 act as 2 and
//    above 36 act as 36.
//  - rsp channel: one transaction per ASCII character, most significant
//    first: integer digits, then '.', then fraction digits. tlast marks the
//    final character; tuser on that character says the fraction digit cap
//    cut off a nonzero remainder.
//  - One value at a time. Each integer digit runs through the shared
//    4-bit-per-cycle divider; characters leave at one per cycle while
//    rsp_tready is high.
//  - req_tready is high only between conversions; the last character may
//    still wait in the result register while the next value is taken.
//  - Stalls: a low rsp_tready holds a valid result and the emitting states.
//  - Reset (synchronous, active high) drops any conversion in flight and
//    clears the result valid.

module fixed_to_radix_digits
   import ftrd_pkg::*;
#(
   parameter int INT_BITS        = DEF_INT_BITS,
   parameter int FRAC_BITS       = DEF_FRAC_BITS,
   parameter int MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
   input  logic clock,
   input  logic reset,
   // req_tdata: int_part, frac_part, radix, zero pad to whole bytes
   input  logic [((INT_BITS + FRAC_BITS + RADIX_W + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // rsp_tdata: char_code, zero pad bit
   output logic [7:0] rsp_tdata,
   // rsp_tuser: truncated
   output logic rsp_tuser,
   output logic rsp_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready
);

   cmd_type cmd;
   sts_type sts;

   logic [INT_BITS-1:0]  in_int;
   logic [FRAC_BITS-1:0] in_frac;
   logic [RADIX_W-1:0]   in_radix;
   logic [CHAR_W-1:0]    rsp_char;

   assign in_int   = req_tdata[INT_BITS-1:0];
   assign in_frac  = req_tdata[INT_BITS +: FRAC_BITS];
   assign in_radix = req_tdata[INT_BITS + FRAC_BITS +: RADIX_W];

   ftrd_ctrl #(
      .INT_BITS (INT_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ftrd_dpath #(
      .INT_BITS        (INT_BITS),
      .FRAC_BITS       (FRAC_BITS),
      .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .in_int    (in_int),
      .in_frac   (in_frac),
      .in_radix  (in_radix),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast),
      .rsp_trunc (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule
